>>> design/bitfield_change_detector_unit_assert.svh
// assertion macros shared by the change detector modules
`ifndef BITFIELD_CHANGE_DETECTOR_UNIT_ASSERT_SVH
`define BITFIELD_CHANGE_DETECTOR_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BCD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define BCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/bcd_pkg.sv
// shared types and constants for the bitfield change detector
`timescale 1ns / 1ps

package bcd_pkg;

    localparam int WORD_INDEX_W   = 6;
    localparam int SAMPLE_W       = 32;
    localparam int SIGNAL_INDEX_W = 11;
    localparam int S_TDATA_W      = 40;
    localparam int M_TDATA_W      = 16;
    localparam int WORD_CMP_W     = 13;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN
    } bcd_state_t;

    typedef struct packed {
        logic pending;
        logic finish;
    } scan_stat_t;

endpackage

>>> design/bitfield_change_detector_unit.sv
// top level of the bitfield change detector
`timescale 1ns / 1ps

// channel  | direction | fields
// s_axis   | in        | tdata: word_index[5:0], sample_word[37:6]
// m_axis   | out       | tdata: signal_index[10:0]; tuser: rising; tlast: last
//
// a sample is accepted, then read from the store, then scanned one changed bit at a time
// the scanner emits one bit a cycle while the output is not stalled
// after reset a clearing pass zeroes the store, no sample taken
// a result waits in the output register while the next sample is accepted
// a stalled output holds the scanner, which holds the next sample's store read

`include "bitfield_change_detector_unit_assert.svh"

module bitfield_change_detector_unit #(
    parameter int WORD_COUNT = 64,
    parameter int WORD_BITS  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bcd_pkg::S_TDATA_W-1:0]  s_tdata,  // word_index, sample_word
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bcd_pkg::M_TDATA_W-1:0]  m_tdata,  // signal_index
    output logic                           m_tuser,  // rising
    output logic                           m_tlast
);

    localparam int ADDR_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int IDX_W  = bcd_pkg::WORD_INDEX_W;
    localparam int SMP_W  = bcd_pkg::SAMPLE_W;
    localparam int SIDX_W = bcd_pkg::SIGNAL_INDEX_W;
    localparam int CMP_W  = bcd_pkg::WORD_CMP_W;
    localparam int BASE_W = IDX_W + $clog2(WORD_BITS + 1);

    bcd_pkg::bcd_state_t state_reg;
    bcd_pkg::bcd_state_t state_next;
    bcd_pkg::scan_stat_t scan_stat;

    logic [ADDR_W-1:0]       addr_reg;
    logic [ADDR_W-1:0]       addr_next;
    logic [WORD_BITS-1:0]    sample_reg;
    logic [WORD_BITS-1:0]    sample_next;
    logic [SIDX_W-1:0]       base_reg;
    logic [SIDX_W-1:0]       base_next;

    logic                    accept;
    logic                    word_ok;
    logic [IDX_W-1:0]        in_word;
    logic [SMP_W-1:0]        in_sample;
    logic [ADDR_W+IDX_W-1:0] addr_wide;
    logic [ADDR_W-1:0]       in_addr;
    logic [WORD_BITS+SMP_W-1:0] sample_wide;
    logic [BASE_W-1:0]       base_full;
    logic [WORD_BITS-1:0]    rd_data;
    logic [WORD_BITS-1:0]    diff;
    logic                    store_busy;
    logic                    rd_en;
    logic                    wr_en;
    logic                    load;

    always_comb
    begin
        in_word     = s_tdata[IDX_W-1:0];
        in_sample   = s_tdata[IDX_W+SMP_W-1:IDX_W];
        accept      = s_tvalid && s_tready;
        word_ok     = CMP_W'(in_word) < CMP_W'(WORD_COUNT);
        addr_wide   = {{ADDR_W{1'b0}}, in_word};
        in_addr     = addr_wide[ADDR_W-1:0];
        sample_wide = {{WORD_BITS{1'b0}}, in_sample};
        base_full   = BASE_W'(in_word) * BASE_W'(WORD_BITS);
        diff        = sample_reg ^ rd_data;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bcd_pkg::ST_CLEAR:
            begin
                if (!store_busy)
                begin
                    state_next = bcd_pkg::ST_IDLE;
                end
            end
            bcd_pkg::ST_IDLE:
            begin
                if (accept && word_ok)
                begin
                    state_next = bcd_pkg::ST_READ;
                end
            end
            bcd_pkg::ST_READ:
            begin
                state_next = (diff == '0) ? bcd_pkg::ST_IDLE : bcd_pkg::ST_SCAN;
            end
            bcd_pkg::ST_SCAN:
            begin
                if (scan_stat.finish)
                begin
                    state_next = bcd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bcd_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready = 1'b0;
        wr_en    = 1'b0;
        load     = 1'b0;
        unique case (state_reg)
            bcd_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            bcd_pkg::ST_READ:
            begin
                wr_en = 1'b1;
                load  = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
        rd_en = accept && word_ok;
    end

    always_comb
    begin
        addr_next   = addr_reg;
        sample_next = sample_reg;
        base_next   = base_reg;
        if (accept)
        begin
            addr_next   = in_addr;
            sample_next = sample_wide[WORD_BITS-1:0];
            base_next   = SIDX_W'(base_full);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bcd_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        sample_reg <= sample_next;
        base_reg   <= base_next;
    end

    bcd_store #(
        .WORD_COUNT (WORD_COUNT),
        .WORD_BITS  (WORD_BITS),
        .ADDR_W     (ADDR_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (in_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (addr_reg),
        .wr_data (sample_reg),
        .busy    (store_busy)
    );

    bcd_scan #(
        .WORD_BITS (WORD_BITS)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .diff_in  (diff),
        .sample   (sample_reg),
        .base     (base_reg),
        .stat     (scan_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `BCD_ASSERT_SAME(a_no_accept_clearing, accept, !store_busy, "transfer taken during clear")
    `BCD_ASSERT_SAME(a_busy_in_clear, store_busy, state_reg == bcd_pkg::ST_CLEAR, "clear outside clear state")
    `BCD_ASSERT_NEXT(a_read_follows, rd_en, state_reg == bcd_pkg::ST_READ, "store read not followed by update")

endmodule

>>> design/bcd_store.sv
// word store with registered read and clearing pass after reset
`timescale 1ns / 1ps

module bcd_store #(
    parameter int WORD_COUNT = 64,
    parameter int WORD_BITS  = 32,
    parameter int ADDR_W     = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output logic [WORD_BITS-1:0] rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [WORD_BITS-1:0] wr_data,
    output logic                 busy
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WORD_COUNT - 1);

    logic [WORD_BITS-1:0] mem [WORD_COUNT];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [ADDR_W-1:0]    clr_addr_reg;
    logic [ADDR_W-1:0]    clr_addr_next;
    logic                 clearing_reg;
    logic                 clearing_next;
    logic                 we;
    logic [ADDR_W-1:0]    wa;
    logic [WORD_BITS-1:0] wd;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        we = clearing_reg || wr_en;
        wa = clearing_reg ? clr_addr_reg : wr_addr;
        wd = clearing_reg ? '0 : wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clearing_reg <= clearing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clearing_reg;

endmodule

>>> design/bcd_scan.sv
// changed-bit scanner, highest bit first, with registered output stage
`timescale 1ns / 1ps

`include "bitfield_change_detector_unit_assert.svh"

module bcd_scan #(
    parameter int WORD_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  logic [WORD_BITS-1:0]                 diff_in,
    input  logic [WORD_BITS-1:0]                 sample,
    input  logic [bcd_pkg::SIGNAL_INDEX_W-1:0]   base,
    output bcd_pkg::scan_stat_t                  stat,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [bcd_pkg::M_TDATA_W-1:0]        m_tdata,  // signal_index
    output logic                                 m_tuser,  // rising
    output logic                                 m_tlast
);

    localparam int POS_W   = $clog2(WORD_BITS);
    localparam int PAD_W   = 1 << POS_W;
    localparam int SIDX_W  = bcd_pkg::SIGNAL_INDEX_W;
    localparam int TDATA_W = bcd_pkg::M_TDATA_W;

    logic [WORD_BITS-1:0] diff_reg;
    logic [WORD_BITS-1:0] diff_next;
    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic [SIDX_W-1:0]    sidx_reg;
    logic [SIDX_W-1:0]    sidx_next;
    logic                 rise_reg;
    logic                 rise_next;
    logic                 last_reg;
    logic                 last_next;
    logic [POS_W-1:0]     pos;
    logic [WORD_BITS-1:0] cleared;
    logic                 pending;
    logic                 adv;

    // binary search for the highest set bit
    function automatic logic [POS_W-1:0] msb_pos(input logic [PAD_W-1:0] v);
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] p_try;
        p = '0;
        for (int k = POS_W - 1; k >= 0; k--)
        begin
            p_try = p | (POS_W'(1) << k);
            if ((v & ({PAD_W{1'b1}} << p_try)) != '0)
            begin
                p = p_try;
            end
        end
        return p;
    endfunction

    always_comb
    begin
        pos     = msb_pos(PAD_W'(diff_reg));
        cleared = diff_reg & ~(WORD_BITS'(1) << pos);
        pending = diff_reg != '0;
        adv     = pending && (!m_tvalid_reg || m_tready);
    end

    always_comb
    begin
        diff_next     = diff_reg;
        m_tvalid_next = m_tvalid_reg;
        sidx_next     = sidx_reg;
        rise_next     = rise_reg;
        last_next     = last_reg;
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (load)
        begin
            diff_next = diff_in;
        end
        else if (adv)
        begin
            diff_next     = cleared;
            m_tvalid_next = 1'b1;
            sidx_next     = base + SIDX_W'(pos);
            rise_next     = sample[pos];
            last_next     = cleared == '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            diff_reg     <= diff_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sidx_reg <= sidx_next;
        rise_reg <= rise_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        stat.pending = pending;
        stat.finish  = adv && !load && (cleared == '0);
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(sidx_reg);
    assign m_tuser  = rise_reg;
    assign m_tlast  = last_reg;

    `BCD_ASSERT_SAME(a_load_when_drained, load, !pending, "scanner loaded while bits remain")
    `BCD_ASSERT_NEXT(a_finish_drains, stat.finish, !stat.pending, "bits left after final transfer")
    `BCD_ASSERT_NEXT(a_load_pending, load, pending == $past(diff_in != '0), "load lost changes")

endmodule
